// ----- src/ealin_pkg.sv -----
// Shared types, constants and arithmetic helpers of the encoder angle linearizer.
`default_nettype none

package ealin_pkg;

    localparam int ENCODER_COUNT = 16;
    localparam int JOINT_COUNT   = 21;
    localparam int WORDS_PER_ENC = 9;
    localparam int WORD_W        = 32;
    localparam int ENC_IDX_W     = 4;
    localparam int JOINT_W       = 5;
    localparam int ENC_AW        = (ENCODER_COUNT > 1) ? $clog2(ENCODER_COUNT) : 1;
    localparam int MAP_SIZE      = 16;

    // 3.3 in Q2.30, rounded down, and 0.67 in Q16.16.
    localparam logic [31:0]        VREF_Q30      = 32'd3543348019;
    localparam logic signed [31:0] DIP_RATIO_Q16 = 32'sd43909;

    localparam int QUEUE_DEPTH = 32;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        REQ_SAMPLE = 1'b0,
        REQ_WRITE  = 1'b1
    } t_req;

    typedef enum logic [3:0] {
        SEL_VOFS   = 4'd0,
        SEL_VSCALE = 4'd1,
        SEL_AOFS   = 4'd2,
        SEL_C0     = 4'd3,
        SEL_C1     = 4'd4,
        SEL_C2     = 4'd5,
        SEL_C3     = 4'd6,
        SEL_JMIN   = 4'd7,
        SEL_JMAX   = 4'd8
    } t_word_sel;

    // One calibration row; word select n sits at bits [32n +: 32].
    typedef struct packed {
        logic signed [31:0] jmax;
        logic signed [31:0] jmin;
        logic signed [31:0] c3;
        logic signed [31:0] c2;
        logic signed [31:0] c1;
        logic signed [31:0] c0;
        logic signed [31:0] aofs;
        logic signed [31:0] vscale;
        logic signed [31:0] vofs;
    } t_cal_row;

    typedef struct packed {
        logic                 valid;
        logic [ENC_IDX_W-1:0] enc;
    } t_ctl;

    typedef struct packed {
        logic                pip_en;
        logic                dip_en;
        logic [JOINT_W-1:0]  joint;
        logic signed [15:0]  pip_cd;
        logic                pip_clamped;
        logic signed [15:0]  dip_cd;
    } t_result_pair;

    localparam logic [JOINT_W-1:0] ENC_JOINT [MAP_SIZE] = '{
        5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd6, 5'd7, 5'd9,
        5'd10, 5'd11, 5'd13, 5'd14, 5'd15, 5'd17, 5'd18, 5'd19
    };
    localparam logic ENC_IS_PIP [MAP_SIZE] = '{
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
        1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1
    };

    function automatic logic [JOINT_W-1:0] joint_of(input logic [ENC_IDX_W-1:0] enc);
        return ENC_JOINT[enc];
    endfunction

    function automatic logic pip_emits(input logic [ENC_IDX_W-1:0] enc);
        return (int'(enc) < ENCODER_COUNT) && (int'(ENC_JOINT[enc]) < JOINT_COUNT);
    endfunction

    function automatic logic dip_emits(input logic [ENC_IDX_W-1:0] enc);
        return (int'(enc) < ENCODER_COUNT) && ENC_IS_PIP[enc]
            && (int'(ENC_JOINT[enc]) + 1 < JOINT_COUNT);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    // Q16.16 product rescale: round half up, then saturate.
    function automatic logic signed [31:0] round_q16(input logic signed [63:0] p);
        logic signed [63:0] r;
        r = (p + 64'sd32768) >>> 16;
        return sat32(r);
    endfunction

    // Takes angle*100 in Q16.16 and divides by 65536 with truncation toward zero.
    function automatic logic signed [15:0] to_centideg(input logic signed [38:0] x);
        logic signed [38:0] y;
        logic signed [22:0] q;
        y = x + ((x < 39'sd0) ? 39'sd65535 : 39'sd0);
        q = 23'(y >>> 16);
        if (q > 23'sd32767) begin
            return 16'sh7FFF;
        end else if (q < -23'sd32768) begin
            return 16'sh8000;
        end
        return q[15:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/ealin_if.sv -----
// Valid/ready channel interfaces for sample or table-write beats and for angle beats.
`default_nettype none

interface ealin_in_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [3:0]         encoder_index;
    logic [3:0]         word_select;
    logic signed [31:0] cal_value;
    logic [23:0]        raw_count;

    modport source (
        output valid, req_type, encoder_index, word_select, cal_value, raw_count,
        input  ready
    );
    modport sink (
        input  valid, req_type, encoder_index, word_select, cal_value, raw_count,
        output ready
    );
endinterface

interface ealin_out_if;
    logic               valid;
    logic               ready;
    logic [4:0]         joint_index;
    logic signed [15:0] angle_centideg;
    logic               was_clamped;
    logic               last;

    modport source (
        output valid, joint_index, angle_centideg, was_clamped, last,
        input  ready
    );
    modport sink (
        input  valid, joint_index, angle_centideg, was_clamped, last,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/encoder_angle_linearizer_top.sv -----
// Top level of the encoder angle linearizer.
//
// Each input beat either writes one calibration word (Q16.16) for an encoder or
// converts one 24-bit ADC sample of that encoder into a joint angle in
// centidegrees; PIP encoders add a second beat with the DIP angle, and last
// marks the final beat of a sample. All nine calibration words of an encoder
// must be written before its samples are sent. The block takes one beat per
// clock cycle while input ready is high: the calibration row is read from a
// synchronous memory in the cycle the sample is accepted and the arithmetic
// is a fully pipelined chain of single multiplies and adds. A 32-entry result
// queue holds a slot for every sample in flight; input ready drops only when
// all slots are taken, which happens when the output side stalls or when PIP
// samples, each needing two output beats, arrive faster than the output can
// send them. There is no clearing pass after reset.
`default_nettype none

module encoder_angle_linearizer_top (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    ealin_in_if.sink    i_in,
    ealin_out_if.source o_out
);
    import ealin_pkg::*;

    logic                w_accept;
    logic                w_is_write;
    logic                w_enc_ok;
    logic                w_we;
    logic                w_room;
    t_ctl                w_in_ctl;
    t_cal_row            w_mem_row;

    t_ctl                w_f_ctl, w_m1_ctl, w_m2_ctl, w_m3_ctl;
    logic signed [31:0]  w_f_v, w_m1_v, w_m2_v, w_m3_v;
    logic signed [31:0]  w_m1_t, w_m2_t, w_m3_t;
    t_cal_row            w_f_row, w_m1_row, w_m2_row, w_m3_row;

    logic                w_push;
    t_result_pair        w_pair;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_is_write = (t_req'(i_in.req_type) == REQ_WRITE);
    assign w_enc_ok   = (int'(i_in.encoder_index) < ENCODER_COUNT);
    assign w_we       = w_accept && w_is_write && w_enc_ok
                        && (i_in.word_select <= SEL_JMAX);

    // Only samples that produce at least one beat enter the datapath.
    assign w_in_ctl.valid = w_accept && !w_is_write
                            && (pip_emits(i_in.encoder_index)
                                || dip_emits(i_in.encoder_index));
    assign w_in_ctl.enc   = i_in.encoder_index;

    assign i_in.ready = w_room;

    ealin_cal_mem u_cal_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (ENC_AW'(i_in.encoder_index)),
        .i_wsel  (i_in.word_select),
        .i_wdata (i_in.cal_value),
        .i_raddr (ENC_AW'(i_in.encoder_index)),
        .o_row   (w_mem_row)
    );

    ealin_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_in_ctl),
        .i_raw   (i_in.raw_count),
        .i_row   (w_mem_row),
        .o_ctl   (w_f_ctl),
        .o_v     (w_f_v),
        .o_row   (w_f_row)
    );

    ealin_mac_step u_mac_c2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_f_ctl),
        .i_v     (w_f_v),
        .i_t     (w_f_row.c3),
        .i_coef  (w_f_row.c2),
        .i_row   (w_f_row),
        .o_ctl   (w_m1_ctl),
        .o_v     (w_m1_v),
        .o_t     (w_m1_t),
        .o_row   (w_m1_row)
    );

    ealin_mac_step u_mac_c1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_m1_ctl),
        .i_v     (w_m1_v),
        .i_t     (w_m1_t),
        .i_coef  (w_m1_row.c1),
        .i_row   (w_m1_row),
        .o_ctl   (w_m2_ctl),
        .o_v     (w_m2_v),
        .o_t     (w_m2_t),
        .o_row   (w_m2_row)
    );

    ealin_mac_step u_mac_c0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_m2_ctl),
        .i_v     (w_m2_v),
        .i_t     (w_m2_t),
        .i_coef  (w_m2_row.c0),
        .i_row   (w_m2_row),
        .o_ctl   (w_m3_ctl),
        .o_v     (w_m3_v),
        .o_t     (w_m3_t),
        .o_row   (w_m3_row)
    );

    ealin_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_m3_ctl),
        .i_t     (w_m3_t),
        .i_row   (w_m3_row),
        .o_push  (w_push),
        .o_pair  (w_pair)
    );

    ealin_out_queue u_out_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_reserve  (w_in_ctl.valid),
        .i_push     (w_push),
        .i_pair     (w_pair),
        .o_has_room (w_room),
        .o_out      (o_out)
    );

    // The last voltage word is consumed by the final Horner step only as a carrier.
    logic w_unused_v;
    assign w_unused_v = ^w_m3_v;

endmodule

`default_nettype wire

// ----- src/ealin_cal_mem.sv -----
// Calibration memory: one row of nine words per encoder, lane write, registered row read.
`default_nettype none

module ealin_cal_mem (
    input  wire logic                           i_clk,
    input  wire logic                           i_we,
    input  wire logic [ealin_pkg::ENC_AW-1:0]   i_waddr,
    input  wire logic [3:0]                     i_wsel,
    input  wire logic [ealin_pkg::WORD_W-1:0]   i_wdata,
    input  wire logic [ealin_pkg::ENC_AW-1:0]   i_raddr,
    output      ealin_pkg::t_cal_row            o_row
);
    import ealin_pkg::*;

    logic [WORDS_PER_ENC*WORD_W-1:0] r_mem [ENCODER_COUNT];
    logic [WORDS_PER_ENC*WORD_W-1:0] r_row;

    // A write lands at the edge that accepts it, so a sample accepted in a later
    // cycle already reads the new word; a write and a sample never share one cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr][int'(i_wsel)*WORD_W +: WORD_W] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= r_mem[i_raddr];
    end

    assign o_row = t_cal_row'(r_row);

endmodule

`default_nettype wire

// ----- src/ealin_front.sv -----
// Front end: ADC count to Q16.16 voltage, offset and scale.
`default_nettype none

module ealin_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ealin_pkg::t_ctl      i_ctl,
    input  wire logic [23:0]          i_raw,
    input  wire ealin_pkg::t_cal_row  i_row,
    output      ealin_pkg::t_ctl      o_ctl,
    output      logic signed [31:0]   o_v,
    output      ealin_pkg::t_cal_row  o_row
);
    import ealin_pkg::*;

    t_ctl               r_s0_ctl, r_s1_ctl, r_s2_ctl, r_s3_ctl, r_s4_ctl, r_s5_ctl;
    logic [55:0]        r_s0_prod;
    logic [23:0]        r_s1_v22;
    logic [18:0]        r_s2_v16;
    logic signed [31:0] r_s3_d;
    logic signed [63:0] r_s4_p;
    logic signed [31:0] r_s5_v;
    t_cal_row           r_s1_row, r_s2_row, r_s3_row, r_s4_row, r_s5_row;

    logic [56:0] w_v22_sum;
    logic [24:0] w_v16_sum;

    assign w_v22_sum = {1'b0, r_s0_prod} + 57'h0_8000_0000;
    assign w_v16_sum = {1'b0, r_s1_v22} + 25'd32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctl.valid <= 1'b0;
            r_s1_ctl.valid <= 1'b0;
            r_s2_ctl.valid <= 1'b0;
            r_s3_ctl.valid <= 1'b0;
            r_s4_ctl.valid <= 1'b0;
            r_s5_ctl.valid <= 1'b0;
        end else begin
            r_s0_ctl.valid <= i_ctl.valid;
            r_s1_ctl.valid <= r_s0_ctl.valid;
            r_s2_ctl.valid <= r_s1_ctl.valid;
            r_s3_ctl.valid <= r_s2_ctl.valid;
            r_s4_ctl.valid <= r_s3_ctl.valid;
            r_s5_ctl.valid <= r_s4_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_ctl.enc <= i_ctl.enc;
        r_s1_ctl.enc <= r_s0_ctl.enc;
        r_s2_ctl.enc <= r_s1_ctl.enc;
        r_s3_ctl.enc <= r_s2_ctl.enc;
        r_s4_ctl.enc <= r_s3_ctl.enc;
        r_s5_ctl.enc <= r_s4_ctl.enc;

        r_s0_prod <= 56'(i_raw) * 56'(VREF_Q30);
        // The memory row arrives alongside stage 0 and travels with the sample.
        r_s1_row  <= i_row;
        r_s1_v22  <= w_v22_sum[55:32];
        r_s2_row  <= r_s1_row;
        r_s2_v16  <= w_v16_sum[24:6];
        r_s3_row  <= r_s2_row;
        r_s3_d    <= sat32($signed({45'd0, r_s2_v16}) - 64'(r_s2_row.vofs));
        r_s4_row  <= r_s3_row;
        r_s4_p    <= 64'(r_s3_d) * 64'(r_s3_row.vscale);
        r_s5_row  <= r_s4_row;
        r_s5_v    <= round_q16(r_s4_p);
    end

    assign o_ctl = r_s5_ctl;
    assign o_v   = r_s5_v;
    assign o_row = r_s5_row;

endmodule

`default_nettype wire

// ----- src/ealin_mac_step.sv -----
// One Horner step, t' = sat(c + round(v*t)), over three stages.
`default_nettype none

module ealin_mac_step (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ealin_pkg::t_ctl      i_ctl,
    input  wire logic signed [31:0]   i_v,
    input  wire logic signed [31:0]   i_t,
    input  wire logic signed [31:0]   i_coef,
    input  wire ealin_pkg::t_cal_row  i_row,
    output      ealin_pkg::t_ctl      o_ctl,
    output      logic signed [31:0]   o_v,
    output      logic signed [31:0]   o_t,
    output      ealin_pkg::t_cal_row  o_row
);
    import ealin_pkg::*;

    t_ctl               r_a_ctl, r_b_ctl, r_c_ctl;
    logic signed [63:0] r_a_p;
    logic signed [31:0] r_b_q, r_c_t;
    logic signed [31:0] r_a_v, r_b_v, r_c_v;
    logic signed [31:0] r_a_coef, r_b_coef;
    t_cal_row           r_a_row, r_b_row, r_c_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl.valid <= 1'b0;
            r_b_ctl.valid <= 1'b0;
            r_c_ctl.valid <= 1'b0;
        end else begin
            r_a_ctl.valid <= i_ctl.valid;
            r_b_ctl.valid <= r_a_ctl.valid;
            r_c_ctl.valid <= r_b_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_ctl.enc <= i_ctl.enc;
        r_b_ctl.enc <= r_a_ctl.enc;
        r_c_ctl.enc <= r_b_ctl.enc;

        r_a_p    <= 64'(i_v) * 64'(i_t);
        r_a_v    <= i_v;
        r_a_coef <= i_coef;
        r_a_row  <= i_row;

        r_b_q    <= round_q16(r_a_p);
        r_b_v    <= r_a_v;
        r_b_coef <= r_a_coef;
        r_b_row  <= r_a_row;

        r_c_t    <= sat32(64'(r_b_coef) + 64'(r_b_q));
        r_c_v    <= r_b_v;
        r_c_row  <= r_b_row;
    end

    assign o_ctl = r_c_ctl;
    assign o_v   = r_c_v;
    assign o_t   = r_c_t;
    assign o_row = r_c_row;

endmodule

`default_nettype wire

// ----- src/ealin_back.sv -----
// Back end: angle offset, joint limit clamp, centidegrees and the derived DIP angle.
`default_nettype none

module ealin_back (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire ealin_pkg::t_ctl         i_ctl,
    input  wire logic signed [31:0]      i_t,
    input  wire ealin_pkg::t_cal_row     i_row,
    output      logic                    o_push,
    output      ealin_pkg::t_result_pair o_pair
);
    import ealin_pkg::*;

    t_ctl               r_b0_ctl, r_b1_ctl, r_b2_ctl, r_b3_ctl, r_b4_ctl, r_b5_ctl;
    logic signed [31:0] r_b0_angle, r_b0_jmin, r_b0_jmax;
    logic signed [31:0] r_b1_angle;
    logic               r_b1_clamped, r_b2_clamped, r_b3_clamped, r_b4_clamped;
    logic               r_b5_clamped;
    logic signed [38:0] r_b2_x;
    logic signed [63:0] r_b2_dp;
    logic signed [15:0] r_b3_cd, r_b4_cd, r_b5_cd;
    logic signed [31:0] r_b3_dq;
    logic signed [38:0] r_b4_dx;
    logic signed [15:0] r_b5_dcd;

    logic signed [31:0] w_clamp_angle;
    logic               w_clamped;

    // Lower limit first; an inverted range gives jmin under jmin, else jmax.
    always_comb begin
        w_clamp_angle = r_b0_angle;
        w_clamped     = 1'b0;
        priority if (r_b0_angle < r_b0_jmin) begin
            w_clamp_angle = r_b0_jmin;
            w_clamped     = 1'b1;
        end else if (r_b0_angle > r_b0_jmax) begin
            w_clamp_angle = r_b0_jmax;
            w_clamped     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_ctl.valid <= 1'b0;
            r_b1_ctl.valid <= 1'b0;
            r_b2_ctl.valid <= 1'b0;
            r_b3_ctl.valid <= 1'b0;
            r_b4_ctl.valid <= 1'b0;
            r_b5_ctl.valid <= 1'b0;
        end else begin
            r_b0_ctl.valid <= i_ctl.valid;
            r_b1_ctl.valid <= r_b0_ctl.valid;
            r_b2_ctl.valid <= r_b1_ctl.valid;
            r_b3_ctl.valid <= r_b2_ctl.valid;
            r_b4_ctl.valid <= r_b3_ctl.valid;
            r_b5_ctl.valid <= r_b4_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b0_ctl.enc <= i_ctl.enc;
        r_b1_ctl.enc <= r_b0_ctl.enc;
        r_b2_ctl.enc <= r_b1_ctl.enc;
        r_b3_ctl.enc <= r_b2_ctl.enc;
        r_b4_ctl.enc <= r_b3_ctl.enc;
        r_b5_ctl.enc <= r_b4_ctl.enc;

        r_b0_angle   <= sat32(64'(i_t) + 64'(i_row.aofs));
        r_b0_jmin    <= i_row.jmin;
        r_b0_jmax    <= i_row.jmax;

        r_b1_angle   <= w_clamp_angle;
        r_b1_clamped <= w_clamped;

        r_b2_x       <= 39'(r_b1_angle) * 39'sd100;
        r_b2_dp      <= 64'(r_b1_angle) * 64'(DIP_RATIO_Q16);
        r_b2_clamped <= r_b1_clamped;

        r_b3_cd      <= to_centideg(r_b2_x);
        r_b3_dq      <= round_q16(r_b2_dp);
        r_b3_clamped <= r_b2_clamped;

        r_b4_cd      <= r_b3_cd;
        r_b4_dx      <= 39'(r_b3_dq) * 39'sd100;
        r_b4_clamped <= r_b3_clamped;

        r_b5_cd      <= r_b4_cd;
        r_b5_dcd     <= to_centideg(r_b4_dx);
        r_b5_clamped <= r_b4_clamped;
    end

    assign o_push             = r_b5_ctl.valid;
    assign o_pair.pip_en      = pip_emits(r_b5_ctl.enc);
    assign o_pair.dip_en      = dip_emits(r_b5_ctl.enc);
    assign o_pair.joint       = joint_of(r_b5_ctl.enc);
    assign o_pair.pip_cd      = r_b5_cd;
    assign o_pair.pip_clamped = r_b5_clamped;
    assign o_pair.dip_cd      = r_b5_dcd;

endmodule

`default_nettype wire

// ----- src/ealin_out_queue.sv -----
// Result queue with slot reservation, and the output register that splits PIP and DIP beats.
`default_nettype none

module ealin_out_queue (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_reserve,
    input  wire logic                    i_push,
    input  wire ealin_pkg::t_result_pair i_pair,
    output      logic                    o_has_room,
    ealin_out_if.source                  o_out
);
    import ealin_pkg::*;

    t_result_pair          r_q [QUEUE_DEPTH];
    logic [QUEUE_AW:0]     r_wr_ptr, r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0]   r_reserved, n_reserved;
    logic                  r_out_valid, n_out_valid;
    logic [JOINT_W-1:0]    r_out_joint, n_out_joint;
    logic signed [15:0]    r_out_cd, n_out_cd;
    logic                  r_out_clamped, n_out_clamped;
    logic                  r_out_last, n_out_last;
    logic                  r_dip_pending, n_dip_pending;
    logic [JOINT_W-1:0]    r_dip_joint, n_dip_joint;
    logic signed [15:0]    r_dip_cd, n_dip_cd;

    t_result_pair          w_head;
    logic                  w_empty;
    logic                  w_load;
    logic                  w_pop;

    assign w_head  = r_q[r_rd_ptr[QUEUE_AW-1:0]];
    assign w_empty = (r_wr_ptr == r_rd_ptr);
    assign w_load  = !r_out_valid || o_out.ready;
    assign w_pop   = w_load && !r_dip_pending && !w_empty;

    // A slot is held from the accepted sample until its entry leaves the queue,
    // so results that are still in the datapath always find room.
    assign o_has_room = (int'(r_reserved) < QUEUE_DEPTH);

    always_comb begin
        n_rd_ptr      = r_rd_ptr;
        n_reserved    = r_reserved + QUEUE_CW'(i_reserve) - QUEUE_CW'(w_pop);
        n_out_valid   = r_out_valid;
        n_out_joint   = r_out_joint;
        n_out_cd      = r_out_cd;
        n_out_clamped = r_out_clamped;
        n_out_last    = r_out_last;
        n_dip_pending = r_dip_pending;
        n_dip_joint   = r_dip_joint;
        n_dip_cd      = r_dip_cd;
        if (w_load) begin
            priority if (r_dip_pending) begin
                n_out_valid   = 1'b1;
                n_out_joint   = r_dip_joint;
                n_out_cd      = r_dip_cd;
                n_out_clamped = 1'b0;
                n_out_last    = 1'b1;
                n_dip_pending = 1'b0;
            end else if (!w_empty) begin
                n_rd_ptr    = r_rd_ptr + 1'b1;
                n_out_valid = 1'b1;
                if (w_head.pip_en) begin
                    n_out_joint   = w_head.joint;
                    n_out_cd      = w_head.pip_cd;
                    n_out_clamped = w_head.pip_clamped;
                    n_out_last    = !w_head.dip_en;
                    n_dip_pending = w_head.dip_en;
                    n_dip_joint   = w_head.joint + 1'b1;
                    n_dip_cd      = w_head.dip_cd;
                end else begin
                    n_out_joint   = w_head.joint + 1'b1;
                    n_out_cd      = w_head.dip_cd;
                    n_out_clamped = 1'b0;
                    n_out_last    = 1'b1;
                end
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_reserved    <= '0;
            r_out_valid   <= 1'b0;
            r_dip_pending <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            r_rd_ptr      <= n_rd_ptr;
            r_reserved    <= n_reserved;
            r_out_valid   <= n_out_valid;
            r_dip_pending <= n_dip_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr[QUEUE_AW-1:0]] <= i_pair;
        end
        r_out_joint   <= n_out_joint;
        r_out_cd      <= n_out_cd;
        r_out_clamped <= n_out_clamped;
        r_out_last    <= n_out_last;
        r_dip_joint   <= n_dip_joint;
        r_dip_cd      <= n_dip_cd;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.joint_index    = r_out_joint;
    assign o_out.angle_centideg = r_out_cd;
    assign o_out.was_clamped    = r_out_clamped;
    assign o_out.last           = r_out_last;

endmodule

`default_nettype wire

// ----- src/ealin_checker.sv -----
// Port-level assertions for the encoder angle linearizer, bound to the top level.
`default_nettype none

module ealin_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [4:0]         i_out_joint_index,
    input wire logic signed [15:0] i_out_angle_centideg,
    input wire logic               i_out_was_clamped,
    input wire logic               i_out_last
);
    import ealin_pkg::*;

    // A stalled output beat keeps its joint, angle and last flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_joint_index)
             && $stable(i_out_angle_centideg) && $stable(i_out_last)))
        else $error("output beat changed while stalled");

    // Reset leaves no output beat pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // A PIP beat is followed at once by its DIP beat on the next joint.
    a_dip_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=>
            (i_out_valid && i_out_last && !i_out_was_clamped
             && (i_out_joint_index == 5'($past(i_out_joint_index) + 5'd1))))
        else $error("DIP beat did not follow its PIP beat");

    // Joint numbers stay inside the joint range.
    a_joint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_out_joint_index) < JOINT_COUNT))
        else $error("joint index out of range");

endmodule

bind encoder_angle_linearizer_top ealin_checker u_ealin_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_out_valid          (o_out.valid),
    .i_out_ready          (o_out.ready),
    .i_out_joint_index    (o_out.joint_index),
    .i_out_angle_centideg (o_out.angle_centideg),
    .i_out_was_clamped    (o_out.was_clamped),
    .i_out_last           (o_out.last)
);

`default_nettype wire
